[design/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int CNT_W = 32;

    // access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_FETCH  = 2'd3;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS_USED  = 2'd2;

    localparam logic [3:0] SET_BITS_RST   = 4'd4;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd1;

    typedef struct packed {
        logic [63:0] access_address;
        logic [1:0]  access_kind;
    } t_in_word;

    typedef struct packed {
        logic             was_hit;
        logic             was_miss;
        logic             was_eviction;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // saturating add of a small increment
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

[design/set_assoc_cache_lru_sim.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// A data access scans the used ways of its set, one way per cycle on the shared
// tag compare, then writes the row back; a fetch skips the scan and the write.
// The update waits on a stalled output; no new access is taken until idle again.
// Reset: a clearing pass over all 2^floor(log2(MAX_SETS)) sets (256 by default)
// invalidates every set; no word is accepted until it is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW     = $clog2(MAX_SETS + 1) - 1;
    localparam int NSETS  = 1 << SW;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW     = WW;
    localparam int AW     = ADDR_WIDTH;

    typedef struct packed {
        logic          valid;
        logic [RW-1:0] rec;
        logic [AW-1:0] tag;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    // configuration registers
    logic [3:0] r_set_bits;
    logic [4:0] r_block_bits;
    logic [3:0] r_ways_used;

    t_state r_state, n_state;

    t_row r_mem [NSETS];
    t_row r_row;

    logic [SW-1:0] r_clr;
    logic [SW-1:0] r_set;
    logic [AW-1:0] r_tag;
    logic [1:0]    r_kind;
    logic [WW-1:0] r_way;

    logic          r_hit_found, r_empty_found, r_vic_found;
    logic [WW-1:0] r_hit_way, r_empty_way, r_vic_way;
    logic [RW-1:0] r_hit_rec, r_vic_rec;

    logic [CNT_W-1:0] r_hits, r_misses, r_evicts;

    logic      r_out_valid;
    t_out_word r_out_word;

    // datapath signals
    logic          in_accept, cfg_wr, commit, scan_en, is_fetch;
    logic [3:0]    sb;
    logic [5:0]    shamt;
    logic [AW-1:0] addr, set_full;
    logic [SW-1:0] set_idx, set_mask;
    logic [AW-1:0] tag_in;
    logic [5:0]    nw, nw_m1;
    logic [WW-1:0] last_way;
    t_way          cur;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    t_row          wr_row, upd_row;

    logic          res_hit, res_miss, res_evict;
    logic [WW-1:0] tw;
    logic [RW-1:0] lim;
    logic          age_all;
    logic [1:0]    hit_inc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SET_BITS_RST;
            r_block_bits <= BLOCK_BITS_RST;
            r_ways_used  <= WAYS_USED_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SET_BITS:   r_set_bits   <= pwdata[3:0];
                REG_BLOCK_BITS: r_block_bits <= pwdata[4:0];
                REG_WAYS_USED:  r_ways_used  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:   prdata = {28'd0, r_set_bits};
            REG_BLOCK_BITS: prdata = {27'd0, r_block_bits};
            REG_WAYS_USED:  prdata = {28'd0, r_ways_used};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // address split and way count
    // ------------------------------------------------------------------
    assign sb       = (r_set_bits > 4'(SW)) ? 4'(SW) : r_set_bits;
    assign shamt    = {2'b00, sb} + {1'b0, r_block_bits};
    assign addr     = i_in_word.access_address[AW-1:0];
    assign set_full = addr >> r_block_bits;
    assign set_mask = ~({SW{1'b1}} << sb);
    assign set_idx  = set_full[SW-1:0] & set_mask;
    assign tag_in   = addr >> shamt;

    always_comb begin
        if (r_ways_used == 4'd0) begin
            nw = 6'd1;
        end else if ({2'b00, r_ways_used} > 6'(MAX_WAYS)) begin
            nw = 6'(MAX_WAYS);
        end else begin
            nw = {2'b00, r_ways_used};
        end
    end
    assign nw_m1    = nw - 6'd1;
    assign last_way = nw_m1[WW-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_accept = i_in_valid && !o_in_stall;
    assign is_fetch  = (r_kind == KIND_FETCH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == {SW{1'b1}}) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_word.access_kind == KIND_FETCH) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_way == last_way) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        scan_en    = (r_state == ST_SCAN);
        commit     = (r_state == ST_UPDATE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + SW'(1);
        end
    end

    // ------------------------------------------------------------------
    // set memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_row  = '0;
        end else begin
            wr_en   = commit && !is_fetch;
            wr_addr = r_set;
            wr_row  = upd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_row;
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_row <= r_mem[set_idx];
    end

    // ------------------------------------------------------------------
    // way scan, one way per cycle on the shared tag compare
    // ------------------------------------------------------------------
    assign cur = r_row[r_way];

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_set         <= set_idx;
            r_tag         <= tag_in;
            r_kind        <= i_in_word.access_kind;
            r_way         <= '0;
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_vic_found   <= 1'b0;
        end else if (scan_en) begin
            r_way <= r_way + WW'(1);
            if (cur.valid) begin
                if (!r_hit_found && cur.tag == r_tag) begin
                    r_hit_found <= 1'b1;
                    r_hit_way   <= r_way;
                    r_hit_rec   <= cur.rec;
                end
                if (!r_vic_found || cur.rec > r_vic_rec) begin
                    r_vic_found <= 1'b1;
                    r_vic_way   <= r_way;
                    r_vic_rec   <= cur.rec;
                end
            end else if (!r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_way   <= r_way;
            end
        end
    end

    // ------------------------------------------------------------------
    // recency update and write back
    // ------------------------------------------------------------------
    assign res_hit   = !is_fetch && r_hit_found;
    assign res_miss  = !is_fetch && !r_hit_found;
    assign res_evict = res_miss && !r_empty_found;

    always_comb begin
        if (r_hit_found) begin
            tw      = r_hit_way;
            lim     = r_hit_rec;
            age_all = 1'b0;
        end else if (r_empty_found) begin
            tw      = r_empty_way;
            lim     = r_vic_rec;
            age_all = 1'b1;
        end else begin
            tw      = r_vic_way;
            lim     = r_vic_rec;
            age_all = 1'b0;
        end
    end

    always_comb begin
        upd_row = r_row;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WW'(j) <= last_way && WW'(j) != tw && r_row[j].valid &&
                (age_all || r_row[j].rec < lim)) begin
                if (r_row[j].rec < RW'(MAX_WAYS - 1)) begin
                    upd_row[j].rec = r_row[j].rec + RW'(1);
                end
            end
        end
        upd_row[tw].rec = '0;
        if (!r_hit_found) begin
            upd_row[tw].valid = 1'b1;
            upd_row[tw].tag   = r_tag;
        end
    end

    // ------------------------------------------------------------------
    // totals and result register
    // ------------------------------------------------------------------
    assign hit_inc = {1'b0, (r_kind == KIND_MODIFY)} + {1'b0, res_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (commit) begin
            r_hits   <= sat_add(r_hits, hit_inc);
            r_misses <= sat_add(r_misses, {1'b0, res_miss});
            r_evicts <= sat_add(r_evicts, {1'b0, res_evict});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_word.was_hit        <= res_hit;
            r_out_word.was_miss       <= res_miss;
            r_out_word.was_eviction   <= res_evict;
            r_out_word.hit_total      <= sat_add(r_hits, hit_inc);
            r_out_word.miss_total     <= sat_add(r_misses, {1'b0, res_miss});
            r_out_word.eviction_total <= sat_add(r_evicts, {1'b0, res_evict});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    // the way scan never runs past the last used way
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_way <= last_way))
        else $error("way scan past last used way");

    // a result is never both a hit and a miss, and evicts only on a miss
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_out_word.was_hit && o_out_word.was_miss) &&
                         (!o_out_word.was_eviction || o_out_word.was_miss)))
        else $error("inconsistent result flags");

    // a committed word never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten");

    // totals never go down
    a_totals_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_hits >= $past(r_hits) && r_misses >= $past(r_misses) &&
                    r_evicts >= $past(r_evicts)))
        else $error("total decreased");
`endif

endmodule
